/* rtl/assert_macros.svh */
// Assertion macros for the checker file of this block.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define RIORU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define RIORU_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* rtl/rioru_pkg.sv */
// Package for the rank-one inverse update block: word types, codes, command structs.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rioru_pkg;

  localparam int unsigned MAX_SIZE_DEF  = 4;
  localparam int unsigned FRAC_BITS_DEF = 24;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned CFG_W         = 3;
  localparam logic [CFG_W-1:0] CFG_RESET = 3'd3;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_READ   = 2'd1,
    OP_QUERY  = 2'd2,
    OP_ACCEPT = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_ZERO = 2'd2,
    ST_SAT  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    WR_ELEM = 2'd0,
    WR_SUB  = 2'd1,
    WR_DIV  = 2'd2
  } wr_sel_e;

  typedef enum logic [1:0] {
    MUL_DOT   = 2'd0,
    MUL_SCALE = 2'd1,
    MUL_SHIFT = 2'd2
  } mul_sel_e;

  // Input word
  typedef struct packed {
    logic [1:0]               opcode;
    logic [1:0]               row_index;
    logic [1:0]               col_index;
    logic signed [DATA_W-1:0] element_value;
    logic signed [DATA_W-1:0] new_row_0;
    logic signed [DATA_W-1:0] new_row_1;
    logic signed [DATA_W-1:0] new_row_2;
    logic signed [DATA_W-1:0] new_row_3;
  } rioru_in_t;

  // Result word
  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic [1:0]               status;
  } rioru_out_t;

  // Controller to datapath
  typedef struct packed {
    logic     take;
    logic     addr_in;
    logic     mem_wr;
    wr_sel_e  wr_sel;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     acc_clr;
    logic     acc_add;
    logic     dot_end;
    logic     dot_query;
    logic     div_start;
    logic     res_elem;
    logic     commit;
  } rioru_cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_e  op;
    logic row_oob;
    logic pend_bad;
    logic ratio_zero;
    logic div_done;
  } rioru_sts_t;

endpackage

`default_nettype wire

/* rtl/rioru_div.sv */
// Bit-serial rounding divider: 64-bit signed numerator by 32-bit signed divisor,
// nearest with ties away from zero, saturated to 32 bits. Uses rioru_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rioru_div (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  input  wire logic signed [63:0]                 num_i,
  input  wire logic signed [rioru_pkg::DATA_W-1:0] den_i,
  output logic                                    done_o,
  output logic signed [rioru_pkg::DATA_W-1:0]     quo_o,
  output logic                                    sat_o
);
  import rioru_pkg::*;

  localparam int unsigned STEPS = 33;

  logic [63:0]       un;
  logic [31:0]       ud;
  logic [63:0]       dsum;
  logic              big;
  logic              run_q;
  logic [5:0]        cnt_q;
  logic [32:0]       rem_q;
  logic [32:0]       work_q;
  logic [31:0]       ud_q;
  logic              neg_q;
  logic              big_q;
  logic [32:0]       trial;
  logic              ge;
  logic [32:0]       rem_d;
  logic [32:0]       work_d;
  logic signed [31:0] fin_val;
  logic              fin_sat;

  // Magnitudes and the rounding bias
  always_comb begin
    un   = num_i[63] ? 64'(-num_i) : 64'(num_i);
    ud   = den_i[31] ? 32'(-den_i) : 32'(den_i);
    dsum = un + 64'(ud >> 1);
    big  = {1'b0, dsum[63:33]} >= ud;
  end

  // One quotient bit per step
  always_comb begin
    trial  = {rem_q[31:0], work_q[32]};
    ge     = trial >= {1'b0, ud_q};
    rem_d  = ge ? (trial - {1'b0, ud_q}) : trial;
    work_d = {work_q[31:0], ge};
  end

  // Sign and saturate the finished quotient
  always_comb begin
    fin_sat = 1'b0;
    fin_val = 32'(work_d);
    if (big_q) begin
      fin_sat = 1'b1;
      fin_val = neg_q ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else if (neg_q) begin
      if (work_d > 33'h0_8000_0000) begin
        fin_sat = 1'b1;
        fin_val = 32'sh8000_0000;
      end else begin
        fin_val = 32'(-work_d);
      end
    end else if (work_d > 33'h0_7fff_ffff) begin
      fin_sat = 1'b1;
      fin_val = 32'sh7fff_ffff;
    end
  end

  // Control of the iteration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= 6'(STEPS - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= 33'(dsum[63:33]);
      work_q <= dsum[32:0];
      ud_q   <= ud;
      neg_q  <= num_i[63] ^ den_i[31];
      big_q  <= big;
    end else if (run_q) begin
      rem_q  <= rem_d;
      work_q <= work_d;
      if (cnt_q == '0) begin
        quo_o <= fin_val;
        sat_o <= fin_sat;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/rioru_ctrl.sv */
// Sequencer of the rank-one inverse update block: steps element writes and reads, dot products
// and column updates through the datapath. Uses rioru_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rioru_ctrl #(
  parameter int unsigned MAX_SIZE = rioru_pkg::MAX_SIZE_DEF,
  localparam int unsigned IDX_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1,
  localparam int unsigned CNT_W = $clog2(MAX_SIZE + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  output logic                       busy_o,
  output logic                       result_valid_o,
  input  wire rioru_pkg::rioru_sts_t sts_i,
  input  wire logic [CNT_W-1:0]      n_i,
  input  wire logic [1:0]            pidx_i,
  output rioru_pkg::rioru_cmd_t      cmd_o,
  output logic [IDX_W-1:0]           row_o,
  output logic [IDX_W-1:0]           col_o
);
  import rioru_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE = 13'b0_0000_0000_0001,
    S_ERD  = 13'b0_0000_0000_0010,
    S_DRD  = 13'b0_0000_0000_0100,
    S_DMUL = 13'b0_0000_0000_1000,
    S_DACC = 13'b0_0000_0001_0000,
    S_DEND = 13'b0_0000_0010_0000,
    S_CSEL = 13'b0_0000_0100_0000,
    S_URD  = 13'b0_0000_1000_0000,
    S_UMUL = 13'b0_0001_0000_0000,
    S_UDST = 13'b0_0010_0000_0000,
    S_UDIV = 13'b0_0100_0000_0000,
    S_UWR  = 13'b0_1000_0000_0000,
    S_FIN  = 13'b1_0000_0000_0000
  } state_e;

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  j_q, j_d;
  logic [CNT_W-1:0]  i_q, i_d;
  logic              last_q, last_d;
  logic              query_q, query_d;
  logic [IDX_W-1:0]  r_idx;
  logic [IDX_W-1:0]  n_last;
  logic              j_end;

  assign r_idx  = IDX_W'(pidx_i);
  assign n_last = IDX_W'(n_i - 1'b1);
  assign j_end  = (j_q == n_last);

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = (state_q == S_FIN);
  assign row_o          = j_q;

  // Column of the element being read
  always_comb begin
    case (state_q)
      S_DRD:   col_o = query_q ? r_idx : IDX_W'(i_q);
      S_URD:   col_o = r_idx;
      default: col_o = last_q ? r_idx : IDX_W'(i_q);
    endcase
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    j_d     = j_q;
    i_d     = i_q;
    last_d  = last_q;
    query_d = query_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.take = 1'b1;
          case (sts_i.op)
            OP_WRITE: begin
              cmd_o.mem_wr  = 1'b1;
              cmd_o.addr_in = 1'b1;
              cmd_o.wr_sel  = WR_ELEM;
              state_d       = S_FIN;
            end
            OP_READ: begin
              cmd_o.addr_in = 1'b1;
              state_d       = S_ERD;
            end
            OP_QUERY: begin
              if (sts_i.row_oob) begin
                state_d = S_FIN;
              end else begin
                j_d           = '0;
                cmd_o.acc_clr = 1'b1;
                query_d       = 1'b1;
                state_d       = S_DRD;
              end
            end
            OP_ACCEPT: begin
              if (sts_i.pend_bad || sts_i.ratio_zero) begin
                state_d = S_FIN;
              end else begin
                i_d     = '0;
                last_d  = 1'b0;
                query_d = 1'b0;
                state_d = S_CSEL;
              end
            end
            default: state_d = S_FIN;
          endcase
        end
      end
      S_ERD: begin
        cmd_o.res_elem = 1'b1;
        state_d        = S_FIN;
      end
      S_DRD: state_d = S_DMUL;
      S_DMUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_DOT;
        state_d       = S_DACC;
      end
      S_DACC: begin
        cmd_o.acc_add = 1'b1;
        if (j_end) begin
          state_d = S_DEND;
        end else begin
          j_d     = IDX_W'(j_q + 1'b1);
          state_d = S_DRD;
        end
      end
      S_DEND: begin
        cmd_o.dot_end   = 1'b1;
        cmd_o.dot_query = query_q;
        if (query_q) begin
          state_d = S_FIN;
        end else begin
          j_d     = '0;
          state_d = S_URD;
        end
      end
      S_CSEL: begin
        // pick the next column, skip the moved one, then scale the moved one
        if (i_q == n_i) begin
          last_d  = 1'b1;
          j_d     = '0;
          state_d = S_URD;
        end else if (i_q == CNT_W'(pidx_i)) begin
          i_d = CNT_W'(i_q + 1'b1);
        end else begin
          j_d           = '0;
          cmd_o.acc_clr = 1'b1;
          state_d       = S_DRD;
        end
      end
      S_URD: state_d = S_UMUL;
      S_UMUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = last_q ? MUL_SHIFT : MUL_SCALE;
        state_d       = S_UDST;
      end
      S_UDST: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_UDIV;
      end
      S_UDIV: begin
        if (sts_i.div_done) begin
          state_d = S_UWR;
        end
      end
      S_UWR: begin
        cmd_o.mem_wr = 1'b1;
        cmd_o.wr_sel = last_q ? WR_DIV : WR_SUB;
        if (j_end) begin
          if (last_q) begin
            cmd_o.commit = 1'b1;
            state_d      = S_FIN;
          end else begin
            i_d     = CNT_W'(i_q + 1'b1);
            state_d = S_CSEL;
          end
        end else begin
          j_d     = IDX_W'(j_q + 1'b1);
          state_d = S_URD;
        end
      end
      S_FIN:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state and loop counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      j_q     <= '0;
      i_q     <= '0;
      last_q  <= 1'b0;
      query_q <= 1'b0;
    end else begin
      state_q <= state_d;
      j_q     <= j_d;
      i_q     <= i_d;
      last_q  <= last_d;
      query_q <= query_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/rioru_dp.sv */
// Datapath of the rank-one inverse update block: inverse store, pending state,
// multiplier, accumulator, rounding and the divider. Uses rioru_pkg and rioru_div.
`timescale 1ns / 1ps
`default_nettype none

module rioru_dp #(
  parameter int unsigned MAX_SIZE  = rioru_pkg::MAX_SIZE_DEF,
  parameter int unsigned FRAC_BITS = rioru_pkg::FRAC_BITS_DEF,
  localparam int unsigned IDX_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1,
  localparam int unsigned CNT_W = $clog2(MAX_SIZE + 1)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [rioru_pkg::CFG_W-1:0]   cfg_data_i,
  input  wire rioru_pkg::rioru_in_t          in_i,
  input  wire rioru_pkg::rioru_cmd_t         cmd_i,
  input  wire logic [IDX_W-1:0]              row_i,
  input  wire logic [IDX_W-1:0]              col_i,
  output rioru_pkg::rioru_sts_t              sts_o,
  output logic [CNT_W-1:0]                   n_o,
  output logic [1:0]                         pidx_o,
  output rioru_pkg::rioru_out_t              out_o
);
  import rioru_pkg::*;

  localparam int unsigned DEPTH  = MAX_SIZE * MAX_SIZE;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned ACC_W  = 2 * DATA_W + CNT_W + 1;

  // inverse store
  logic signed [DATA_W-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0]         vld_q;
  logic signed [DATA_W-1:0] rd_raw_q;
  logic                     rd_vld_q;
  logic signed [DATA_W-1:0] rd_val;
  logic [ADDR_W-1:0]        addr;
  logic                     in_rng;
  logic                     rng_q;
  logic                     wr_en;
  logic signed [DATA_W-1:0] wr_data;

  // pending state and config
  logic [CFG_W-1:0]         size_q;
  logic signed [DATA_W-1:0] prow_q [MAX_SIZE];
  logic signed [DATA_W-1:0] new_row [4];
  logic signed [DATA_W-1:0] ratio_q;
  logic [1:0]               pidx_q;
  logic                     pv_q;

  // arithmetic
  logic signed [63:0]       prod_d, prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  rnd_sum, rnd_sh;
  logic signed [DATA_W-1:0] rnd_val;
  logic                     rnd_sat;
  logic signed [DATA_W-1:0] s_q;
  logic signed [DATA_W:0]   diff;
  logic signed [DATA_W-1:0] sub_val;
  logic                     sub_sat;
  logic                     div_done;
  logic signed [DATA_W-1:0] div_quo;
  logic                     div_sat;

  // result
  logic signed [DATA_W-1:0] res_q;
  status_e                  st_q;
  logic                     sat_q;

  // Clamp the active size
  always_comb begin
    if (int'(size_q) < 1) begin
      n_o = CNT_W'(1);
    end else if (int'(size_q) > int'(MAX_SIZE)) begin
      n_o = CNT_W'(MAX_SIZE);
    end else begin
      n_o = CNT_W'(size_q);
    end
  end

  assign pidx_o = pidx_q;

  // Element address from the word or from the sequencer
  always_comb begin
    in_rng = (int'(in_i.row_index) < int'(MAX_SIZE)) &&
             (int'(in_i.col_index) < int'(MAX_SIZE));
    if (cmd_i.addr_in) begin
      addr = ADDR_W'(int'(in_i.row_index) * MAX_SIZE + int'(in_i.col_index));
    end else begin
      addr = ADDR_W'(int'(row_i) * MAX_SIZE + int'(col_i));
    end
  end

  assign wr_en  = cmd_i.mem_wr && (!cmd_i.addr_in || in_rng);
  assign rd_val = rd_vld_q ? rd_raw_q : '0;

  // Write-back value
  always_comb begin
    case (cmd_i.wr_sel)
      WR_ELEM: wr_data = in_i.element_value;
      WR_SUB:  wr_data = sub_val;
      WR_DIV:  wr_data = div_quo;
      default: wr_data = '0;
    endcase
  end

  // Store array and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[addr] <= wr_data;
    end
    rd_raw_q <= mem_q[addr];
  end

  // Entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[addr] <= 1'b1;
      end
      rd_vld_q <= vld_q[addr];
    end
  end

  // Multiply: dot term, column scale, or fixed-point shift of the moved column
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_DOT:   prod_d = rd_val * prow_q[row_i];
      MUL_SCALE: prod_d = rd_val * s_q;
      MUL_SHIFT: prod_d = 64'(rd_val) <<< FRAC_BITS;
      default:   prod_d = '0;
    endcase
  end

  // Round half up, drop the fraction, saturate
  always_comb begin
    rnd_sum = acc_q + (ACC_W'(1) << (FRAC_BITS - 1));
    rnd_sh  = rnd_sum >>> FRAC_BITS;
    rnd_sat = !((&rnd_sh[ACC_W-1:DATA_W-1]) || !(|rnd_sh[ACC_W-1:DATA_W-1]));
    if (rnd_sat) begin
      rnd_val = rnd_sh[ACC_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      rnd_val = rnd_sh[DATA_W-1:0];
    end
  end

  // Saturating subtract of the scaled moved column
  always_comb begin
    diff    = (DATA_W + 1)'(rd_val) - (DATA_W + 1)'(div_quo);
    sub_sat = diff[DATA_W] != diff[DATA_W-1];
    if (sub_sat) begin
      sub_val = diff[DATA_W] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sub_val = diff[DATA_W-1:0];
    end
  end

  rioru_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (prod_q),
    .den_i   (ratio_q),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .sat_o   (div_sat)
  );

  assign new_row[0] = in_i.new_row_0;
  assign new_row[1] = in_i.new_row_1;
  assign new_row[2] = in_i.new_row_2;
  assign new_row[3] = in_i.new_row_3;

  // Payload registers: product, sum, scale, pending row, range flag
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (cmd_i.dot_end && !cmd_i.dot_query) begin
      s_q <= rnd_val;
    end
    if (cmd_i.take) begin
      rng_q <= in_rng;
    end
    if (cmd_i.take && (op_e'(in_i.opcode) == OP_QUERY) && !sts_o.row_oob) begin
      for (int k = 0; k < int'(MAX_SIZE); k++) begin
        prow_q[k] <= (k < 4) ? new_row[k % 4] : '0;
      end
    end
  end

  // Pending state, config register, result and status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= CFG_RESET;
      pv_q    <= 1'b0;
      pidx_q  <= '0;
      ratio_q <= '0;
      res_q   <= '0;
      st_q    <= ST_OK;
      sat_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        size_q <= cfg_data_i;
      end
      if (cmd_i.take) begin
        sat_q <= 1'b0;
        res_q <= '0;
        st_q  <= ST_OK;
        case (op_e'(in_i.opcode))
          OP_QUERY: begin
            if (sts_o.row_oob) begin
              pv_q <= 1'b0;
              st_q <= ST_NONE;
            end else begin
              pv_q   <= 1'b1;
              pidx_q <= in_i.row_index;
            end
          end
          OP_ACCEPT: begin
            if (sts_o.pend_bad) begin
              st_q <= ST_NONE;
            end else if (sts_o.ratio_zero) begin
              st_q <= ST_ZERO;
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.res_elem) begin
        res_q <= rng_q ? rd_val : '0;
      end
      if (cmd_i.dot_end) begin
        if (cmd_i.dot_query) begin
          ratio_q <= rnd_val;
          res_q   <= rnd_val;
        end
        if (rnd_sat) begin
          sat_q <= 1'b1;
        end
      end
      if (div_done && div_sat) begin
        sat_q <= 1'b1;
      end
      if (cmd_i.mem_wr && (cmd_i.wr_sel == WR_SUB) && sub_sat) begin
        sat_q <= 1'b1;
      end
      if (cmd_i.commit) begin
        pv_q <= 1'b0;
      end
    end
  end

  // Status toward the sequencer
  always_comb begin
    sts_o.op         = op_e'(in_i.opcode);
    sts_o.row_oob    = int'(in_i.row_index) >= int'(n_o);
    sts_o.pend_bad   = !pv_q || (int'(pidx_q) >= int'(n_o));
    sts_o.ratio_zero = (ratio_q == '0);
    sts_o.div_done   = div_done;
  end

  assign out_o.result_value = res_q;
  assign out_o.status       = sat_q ? ST_SAT : st_q;

endmodule

`default_nettype wire

/* rtl/rank_one_inverse_ratio_update.sv */
// Rank-one (Sherman-Morrison) inverse update over an n x n Q8.24 store, n = matrix_size.
// Accept sends each updated element through the bit-serial divider, one quotient bit per
// cycle. One word at a time.
// The result is shown for one cycle with result_valid_o; the receiver cannot stall.
// Reset (rst_ni low, async): store reads as zero, nothing pending, matrix_size 3.
`timescale 1ns / 1ps
`default_nettype none

module rank_one_inverse_ratio_update #(
  parameter int unsigned MAX_SIZE  = rioru_pkg::MAX_SIZE_DEF,
  parameter int unsigned FRAC_BITS = rioru_pkg::FRAC_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire rioru_pkg::rioru_in_t        in_i,
  output logic                             result_valid_o,
  output rioru_pkg::rioru_out_t            out_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [rioru_pkg::CFG_W-1:0] cfg_data_i
);
  import rioru_pkg::*;

  localparam int unsigned IDX_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_SIZE + 1);

  rioru_cmd_t       cmd;
  rioru_sts_t       sts;
  logic [CNT_W-1:0] n_act;
  logic [1:0]       pidx;
  logic [IDX_W-1:0] row;
  logic [IDX_W-1:0] col;

  // Config writes land only while idle
  assign cfg_ready_o = !busy;

  rioru_ctrl #(
    .MAX_SIZE (MAX_SIZE)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_o         (busy),
    .result_valid_o (result_valid_o),
    .sts_i          (sts),
    .n_i            (n_act),
    .pidx_i         (pidx),
    .cmd_o          (cmd),
    .row_o          (row),
    .col_o          (col)
  );

  rioru_dp #(
    .MAX_SIZE  (MAX_SIZE),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .cmd_i      (cmd),
    .row_i      (row),
    .col_i      (col),
    .sts_o      (sts),
    .n_o        (n_act),
    .pidx_o     (pidx),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire

/* rtl/rioru_chk.sv */
// Port-level checker for the rank-one inverse update block, bound to the top level.
// Uses rioru_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rioru_chk (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  start,
  input wire logic                  busy,
  input wire rioru_pkg::rioru_in_t  in_i,
  input wire logic                  result_valid_o,
  input wire rioru_pkg::rioru_out_t out_o
);
  import rioru_pkg::*;

  // A result strobe lasts one cycle
  `RIORU_ASSERT_NXT(a_strobe_single, clk_i, rst_ni, result_valid_o, !result_valid_o)

  // A result only closes a word in flight
  `RIORU_ASSERT_IMP(a_strobe_busy, clk_i, rst_ni, result_valid_o, busy)

  // A taken word makes the block busy
  `RIORU_ASSERT_NXT(a_take_busy, clk_i, rst_ni, start && !busy, busy)

  // An element write answers in the next cycle
  `RIORU_ASSERT_NXT(a_write_quick, clk_i, rst_ni, start && !busy && in_i.opcode == OP_WRITE, result_valid_o)

  // Refused words carry a zero value
  `RIORU_ASSERT_IMP(a_refused_zero, clk_i, rst_ni, result_valid_o && (out_o.status == ST_NONE || out_o.status == ST_ZERO), out_o.result_value == 0)

endmodule

bind rank_one_inverse_ratio_update rioru_chk u_rioru_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .in_i           (in_i),
  .result_valid_o (result_valid_o),
  .out_o          (out_o)
);

`default_nettype wire

/* verif/rank_one_inverse_ratio_update_tb.sv */
// Self-checking testbench for rank_one_inverse_ratio_update: directed and random commands
// checked word by word against a scoreboard that tracks the inverse and the pending update.
// Depends on rioru_pkg and the block's RTL only.
`timescale 1ns / 1ps

module rank_one_inverse_ratio_update_tb;
  import rioru_pkg::*;

  // Scoreboard: own copy of the inverse store, pending update and matrix size
  class inverse_update_scoreboard;
    int               inv_m [4][4];
    int               pend_row [4];
    int               pend_ratio;
    int unsigned      pend_idx;
    bit               pend_ok;
    logic [CFG_W-1:0] size_reg = CFG_RESET;
    bit               sat_seen;
    int               errors;
    rioru_out_t       expected_q [$];

    function int active_n();
      if (size_reg < 1) return 1;
      if (size_reg > 4) return 4;
      return int'(size_reg);
    endfunction

    function int clamp32(longint x);
      if (x > 64'sd2147483647) begin
        sat_seen = 1;
        return 32'h7fff_ffff;
      end
      if (x < -64'sd2147483648) begin
        sat_seen = 1;
        return 32'h8000_0000;
      end
      return int'(x);
    endfunction

    // Dot product of the pending row with one column, round half up to Q8.24
    function int dot_round(int col, int n);
      longint hs, ls, lq, lr, t, tot, ahi, alo;
      hs = 0;
      ls = 0;
      for (int k = 0; k < n; k++) begin
        ahi = longint'(pend_row[k]) >>> 16;
        alo = longint'(pend_row[k]) - ahi * 65536;
        hs += ahi * longint'(inv_m[k][col]);
        ls += alo * longint'(inv_m[k][col]);
      end
      lq = ls >>> 16;
      lr = ls - lq * 65536;
      t = hs + lq;
      if (t > 64'sh4000_0000_0000) begin
        sat_seen = 1;
        return 32'h7fff_ffff;
      end
      if (t < -64'sh4000_0000_0000) begin
        sat_seen = 1;
        return 32'h8000_0000;
      end
      tot = t * 65536 + lr + (64'sd1 << (FRAC_BITS_DEF - 1));
      return clamp32(tot >>> FRAC_BITS_DEF);
    endfunction

    // Divide, round to nearest with ties away from zero, saturate
    function int div_round(longint num, longint den);
      longint unsigned un, ud, q;
      bit neg;
      un = (num < 0) ? longint'(-num) : num;
      ud = (den < 0) ? longint'(-den) : den;
      q = (un + ud / 2) / ud;
      neg = (num < 0) != (den < 0);
      if (neg) begin
        if (q > 64'd2147483648) begin
          sat_seen = 1;
          return 32'h8000_0000;
        end
        return int'(-longint'(q));
      end
      if (q > 64'd2147483647) begin
        sat_seen = 1;
        return 32'h7fff_ffff;
      end
      return int'(q);
    endfunction

    // Note an accepted command word and queue its expected result
    function void note_command(rioru_in_t c);
      rioru_out_t exp_w;
      int n, r, s, qv;
      n = active_n();
      exp_w.result_value = 0;
      exp_w.status = ST_OK;
      sat_seen = 0;
      case (op_e'(c.opcode))
        OP_WRITE: inv_m[c.row_index][c.col_index] = c.element_value;
        OP_READ:  exp_w.result_value = inv_m[c.row_index][c.col_index];
        OP_QUERY: begin
          if (c.row_index >= n) begin
            exp_w.status = ST_NONE;
            pend_ok = 0;
          end else begin
            pend_row[0] = c.new_row_0;
            pend_row[1] = c.new_row_1;
            pend_row[2] = c.new_row_2;
            pend_row[3] = c.new_row_3;
            pend_ratio = dot_round(c.row_index, n);
            pend_idx = c.row_index;
            pend_ok = 1;
            exp_w.result_value = pend_ratio;
            if (sat_seen) exp_w.status = ST_SAT;
          end
        end
        default: begin
          r = pend_idx;
          if (!pend_ok || r >= n) begin
            exp_w.status = ST_NONE;
          end else if (pend_ratio == 0) begin
            exp_w.status = ST_ZERO;
          end else begin
            for (int i = 0; i < n; i++) begin
              if (i == r) continue;
              s = dot_round(i, n);
              for (int j = 0; j < n; j++) begin
                qv = div_round(longint'(inv_m[j][r]) * longint'(s), pend_ratio);
                inv_m[j][i] = clamp32(longint'(inv_m[j][i]) - longint'(qv));
              end
            end
            for (int j = 0; j < n; j++)
              inv_m[j][r] = div_round(longint'(inv_m[j][r]) * 64'sd16777216, pend_ratio);
            pend_ok = 0;
            if (sat_seen) exp_w.status = ST_SAT;
          end
        end
      endcase
      expected_q.push_back(exp_w);
    endfunction

    // Compare one result word with the oldest expectation
    function void check_result(rioru_out_t got);
      rioru_out_t exp_w;
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result: value %h status %0d", $time, got.result_value,
                 got.status);
        errors++;
        return;
      end
      exp_w = expected_q.pop_front();
      if (got.result_value !== exp_w.result_value || got.status !== exp_w.status) begin
        $display("%0t mismatch: expected value %h status %0d, got value %h status %0d",
                 $time, exp_w.result_value, exp_w.status, got.result_value, got.status);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i = 0;
  logic             rst_ni = 0;
  logic             start = 0;
  logic             busy;
  rioru_in_t        in_i = '0;
  logic             result_valid_o;
  rioru_out_t       out_o;
  logic             cfg_valid_i = 0;
  logic             cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i = '0;

  inverse_update_scoreboard sb = new();
  int words_sent = 0;

  rank_one_inverse_ratio_update dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .in_i(in_i),
    .result_valid_o(result_valid_o), .out_o(out_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Check every result word at the edge that ends its cycle
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) sb.check_result(out_o);
  end

  function automatic rioru_in_t make_cmd(op_e op, int row, int col, int ev,
                                         int v0, int v1, int v2, int v3);
    rioru_in_t c;
    c.opcode = op;
    c.row_index = row[1:0];
    c.col_index = col[1:0];
    c.element_value = ev;
    c.new_row_0 = v0;
    c.new_row_1 = v1;
    c.new_row_2 = v2;
    c.new_row_3 = v3;
    return c;
  endfunction

  // Mostly small Q8.24 values, some full range and some extremes
  function automatic int rand_word();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return $urandom;
    if (pick == 1) return ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
    return int'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
  endfunction

  // Drive one command word and hold it until accepted
  task automatic send_word(rioru_in_t c);
    @(negedge clk_i);
    in_i <= c;
    start <= 1;
    do @(posedge clk_i); while (busy);
    sb.note_command(c);
    words_sent++;
  endtask

  // Idle the command side: mostly short gaps, a few long, often none
  task automatic input_gap();
    int r, k;
    r = $urandom_range(0, 99);
    k = (r < 50) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (k > 0) begin
      @(negedge clk_i);
      start <= 0;
      repeat (k - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_gap(rioru_in_t c);
    send_word(c);
    input_gap();
  endtask

  // Write matrix_size once the block has returned every word
  task automatic write_size(logic [CFG_W-1:0] sz);
    @(negedge clk_i);
    start <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_valid_i <= 1;
    cfg_data_i <= sz;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.size_reg = sz;
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  // Load a well-conditioned matrix: about one on the diagonal, small elsewhere
  task automatic load_matrix(int n);
    int v;
    for (int j = 0; j < n; j++)
      for (int i = 0; i < n; i++) begin
        v = int'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
        if (i == j) v += 32'h0100_0000;
        send_gap(make_cmd(OP_WRITE, j, i, v, 0, 0, 0, 0));
      end
  endtask

  task automatic random_command();
    send_gap(make_cmd(op_e'($urandom_range(0, 3)), $urandom_range(0, 3),
                      $urandom_range(0, 3), $urandom, rand_word(), rand_word(),
                      rand_word(), rand_word()));
  endtask

  // Query a random row of the active square, sometimes disturb, usually accept, then read up to two elements
  task automatic update_sequence(int n);
    int r;
    r = $urandom_range(0, n - 1);
    send_gap(make_cmd(OP_QUERY, r, 0, 0, rand_word(), rand_word(), rand_word(),
                      rand_word()));
    if ($urandom_range(0, 7) == 0)
      send_gap(make_cmd(OP_WRITE, $urandom_range(0, 3), $urandom_range(0, 3),
                        rand_word(), 0, 0, 0, 0));
    if ($urandom_range(0, 9) != 0)
      send_gap(make_cmd(OP_ACCEPT, 0, 0, 0, 0, 0, 0, 0));
    repeat ($urandom_range(0, 2))
      send_gap(make_cmd(OP_READ, $urandom_range(0, 3), $urandom_range(0, 3), 0, 0, 0,
                        0, 0));
  endtask

  initial begin
    int n, seqs;
    logic [CFG_W-1:0] sizes [8] = '{3'd4, 3'd1, 3'd2, 3'd3, 3'd0, 3'd7, 3'd5, 3'd6};

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;

    // Directed: extremes, every opcode, refusals, saturation
    write_size(3'd4);
    send_word(make_cmd(OP_READ, 2, 1, 0, 0, 0, 0, 0));
    send_word(make_cmd(OP_ACCEPT, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_cmd(OP_WRITE, 0, 0, 32'h7fff_ffff, 0, 0, 0, 0));
    send_word(make_cmd(OP_WRITE, 3, 3, 32'h8000_0000, 0, 0, 0, 0));
    send_word(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_cmd(OP_READ, 3, 3, 0, 0, 0, 0, 0));
    send_word(make_cmd(OP_QUERY, 1, 0, 0, 32'h0100_0000, 32'h7fff_ffff, -1, 5));
    send_word(make_cmd(OP_ACCEPT, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_cmd(OP_QUERY, 3, 0, 0, 32'h7fff_ffff, 32'h8000_0000,
                       32'h7fff_ffff, 32'h8000_0000));
    send_word(make_cmd(OP_ACCEPT, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_cmd(OP_QUERY, 0, 0, 0, 32'h8000_0000, 32'h8000_0000, 0, 0));
    send_word(make_cmd(OP_ACCEPT, 0, 0, 0, 0, 0, 0, 0));
    load_matrix(4);
    send_word(make_cmd(OP_QUERY, 3, 0, 0, 32'h0080_0000, 32'h0010_0000, 0,
                       32'h0120_0000));
    send_word(make_cmd(OP_WRITE, 0, 3, 32'h0100_0000, 0, 0, 0, 0));
    send_word(make_cmd(OP_ACCEPT, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_cmd(OP_QUERY, 3, 0, 0, 32'h0100_0000, 0, 0, 32'h0100_0000));
    // Pending row falls outside the square once the size shrinks
    write_size(3'd2);
    send_word(make_cmd(OP_ACCEPT, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_cmd(OP_QUERY, 3, 0, 0, 1, 1, 1, 1));
    send_word(make_cmd(OP_ACCEPT, 0, 0, 0, 0, 0, 0, 0));

    // Random phases over all sizes, extremes included
    for (int ph = 0; words_sent < 1950; ph++) begin
      write_size((ph < 8) ? sizes[ph] : 3'($urandom_range(0, 7)));
      n = sb.active_n();
      seqs = 0;
      load_matrix(n);
      for (int it = 0; it < 60 && words_sent < 1950; it++) begin
        if ($urandom_range(0, 9) < 7) begin
          update_sequence(n);
          if (++seqs % 6 == 0) load_matrix(n);
        end else begin
          random_command();
        end
      end
    end

    @(negedge clk_i);
    start <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (700) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("[rank_one_inverse_ratio_update] OK");
    else
      $display("[rank_one_inverse_ratio_update] ERROR");
    $finish;
  end

  // Stop a hung run
  initial begin
    #80ms;
    $display("[rank_one_inverse_ratio_update] ERROR");
    $finish;
  end
endmodule
